// ===== sv/tsmm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsmm_pkg
// Shared types and constants of the three-sensor median/minimum filter.
// ----------------------------------------------------------------------------
package tsmm_pkg;

	// One temperature in tenths of a degree, two's complement.
	typedef logic signed [15:0] temp_t;

	// Every window entry holds this value after reset (85.0 degrees).
	localparam temp_t RESET_TEMP = 16'sd850;

	// Configuration port geometry: registers sit at byte address 4*index.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// Register indexes, taken from paddr[2].
	typedef enum logic {
		REG_USE_EXTERNAL = 1'b0,
		REG_UNUSED       = 1'b1
	} reg_index_t;

endpackage

// ===== sv/tsmm_median.sv =====
// ----------------------------------------------------------------------------
// tsmm_median
// Median of one window by rank counting over all pairs of entries.
// ----------------------------------------------------------------------------
module tsmm_median
	import tsmm_pkg::*;
#(
	parameter int unsigned WINDOW_LEN = 5
) (
	input  temp_t win [WINDOW_LEN],
	output temp_t median
);

	localparam int unsigned RANK_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW_LEN / 2);

	// Rank of an entry is its place in the window sorted from largest down;
	// equal values are ordered by position so that each rank is taken once.
	logic [RANK_W-1:0] rank [WINDOW_LEN];
	logic [WINDOW_LEN-1:0] pick;

	always_comb begin
		for (int i = 0; i < WINDOW_LEN; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW_LEN; j++) begin
				if ((win[j] > win[i]) || ((j < i) && (win[j] == win[i]))) begin
					rank[i] = rank[i] + RANK_W'(1);
				end
			end
			pick[i] = (rank[i] == MID_RANK);
		end
	end

	// Exactly one entry carries the middle rank, so an OR of the gated
	// entries selects it.
	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			if (pick[i]) begin
				median = median | win[i];
			end
		end
	end

endmodule

// ===== sv/tsmm_window.sv =====
// ----------------------------------------------------------------------------
// tsmm_window
// Sliding window of one sensor with its median.
// ----------------------------------------------------------------------------
module tsmm_window
	import tsmm_pkg::*;
#(
	parameter int unsigned WINDOW_LEN = 5
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift_en,
	input  temp_t sample,
	output temp_t newest,
	output temp_t median
);

	// Entry 0 is the oldest, entry WINDOW_LEN-1 the newest.
	temp_t win_q [WINDOW_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= RESET_TEMP;
			end
		end else if (shift_en) begin
			for (int i = 1; i < WINDOW_LEN; i++) begin
				win_q[i-1] <= win_q[i];
			end
			win_q[WINDOW_LEN-1] <= sample;
		end
	end

	assign newest = win_q[WINDOW_LEN-1];

	tsmm_median #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_median (
		.win   (win_q),
		.median(median)
	);

endmodule

// ===== sv/three_sensor_median_min_filter.sv =====
// ----------------------------------------------------------------------------
// three_sensor_median_min_filter
// Three sliding-window median filters followed by a minimum of the three
// medians, with an external temperature bypass chosen by a register.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                     Word
// sample    sample_valid / sample_stall   sample_a, sample_b, sample_c,
//                                         external_temp
// result    result_valid / result_stall   filtered_temp
// config    APB psel/penable/pready       paddr, pwdata, prdata
//
// A word is accepted every cycle while the result side keeps up. The windows
// shift and stage one fills at the accepting edge; the median and minimum
// network settles into the result register once stage two has room. Reset
// brings every window entry to 85.0 degrees and selects the sensors. A
// stalled result holds its word; a second word waits in stage one, and only
// with both full does sample_stall rise.
// ----------------------------------------------------------------------------
module three_sensor_median_min_filter
	import tsmm_pkg::*;
#(
	parameter int unsigned WINDOW_LEN = 5
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               sample_valid,
	output logic               sample_stall,
	input  temp_t              sample_a,
	input  temp_t              sample_b,
	input  temp_t              sample_c,
	input  temp_t              external_temp,

	output logic               result_valid,
	input  logic               result_stall,
	output temp_t              filtered_temp,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// ------------------------------------------------------------------
	// Configuration register. Only bit 0 of the written data matters, and
	// writes with paddr[2] set (the unused register) are dropped.
	// ------------------------------------------------------------------
	logic       use_external_q;
	reg_index_t reg_index;
	logic       cfg_write;

	assign pready    = 1'b1;
	assign reg_index = reg_index_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_external_q <= 1'b0;
		end else if (cfg_write && (reg_index == REG_USE_EXTERNAL)) begin
			use_external_q <= pwdata[0];
		end
	end

	always_comb begin
		case (reg_index)
			REG_USE_EXTERNAL: prdata = {{(PDATA_W-1){1'b0}}, use_external_q};
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control. Stage one holds the mode and external value of the
	// word most recently accepted; stage two is the result.
	// ------------------------------------------------------------------
	logic  valid_s1;
	logic  external_s1;
	temp_t external_temp_s1;
	logic  valid_s2;
	temp_t filtered_s2;

	logic  s2_free;
	logic  s1_advance;
	logic  sample_accept;
	logic  shift_en;

	assign s2_free       = !valid_s2 || !result_stall;
	assign s1_advance    = valid_s1 && s2_free;
	// Stage one can take a word when it is empty or draining this cycle.
	assign sample_stall  = valid_s1 && !s2_free;
	assign sample_accept = sample_valid && !sample_stall;
	// In bypass mode the windows keep their contents.
	assign shift_en      = sample_accept && !use_external_q;

	// ------------------------------------------------------------------
	// Windows and medians. The medians are read from the windows as the
	// stage-one word left them; a newly accepted word shifts them at the
	// same edge at which that result is captured.
	// ------------------------------------------------------------------
	temp_t newest_a, newest_b, newest_c;
	temp_t median_a, median_b, median_c;

	tsmm_window #(.WINDOW_LEN(WINDOW_LEN)) u_window_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift_en(shift_en),
		.sample  (sample_a),
		.newest  (newest_a),
		.median  (median_a)
	);

	tsmm_window #(.WINDOW_LEN(WINDOW_LEN)) u_window_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift_en(shift_en),
		.sample  (sample_b),
		.newest  (newest_b),
		.median  (median_b)
	);

	tsmm_window #(.WINDOW_LEN(WINDOW_LEN)) u_window_c (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift_en(shift_en),
		.sample  (sample_c),
		.newest  (newest_c),
		.median  (median_c)
	);

	// Smallest of the three medians, or the external value in bypass.
	temp_t min_ab;
	temp_t min_abc;
	temp_t result_next;

	assign min_ab      = (median_a < median_b) ? median_a : median_b;
	assign min_abc     = (min_ab < median_c) ? min_ab : median_c;
	assign result_next = external_s1 ? external_temp_s1 : min_abc;

	// ------------------------------------------------------------------
	// Pipeline registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_accept) begin
			external_s1      <= use_external_q;
			external_temp_s1 <= external_temp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			filtered_s2 <= result_next;
		end
	end

	assign result_valid  = valid_s2;
	assign filtered_temp = filtered_s2;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// An accepted word always occupies stage one in the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		sample_accept |=> valid_s1)
		else $error("accepted word did not reach stage one");

	// A stage-one word moves to the result register when it has room.
	a_s1_reaches_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_advance |=> result_valid)
		else $error("stage-one word was lost on its way to the result");

	// Windows only move when a sensor-mode word is accepted.
	a_windows_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!shift_en |=> ($stable(newest_a) && $stable(newest_b) && $stable(newest_c)))
		else $error("window changed without an accepted sensor word");

	// A stalled result with stage one full must stall the sample side.
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && result_stall) |-> (sample_stall && !s1_advance))
		else $error("pipeline full but sample side not stalled");

endmodule

// ===== verif/tsmm_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsmm_tb_pkg
// Tracks the three sensor windows and the source selection, works out the
// filtered temperature of every accepted word and checks the result words.
// ----------------------------------------------------------------------------
package tsmm_tb_pkg;
	import tsmm_pkg::*;

	localparam int TAP_COUNT = 5;

	class min_median_tracker;
		temp_t windows[3][TAP_COUNT];
		bit    external_mode;
		temp_t expected_temps[$];
		int    mismatches;

		function new();
			foreach (windows[ch, i]) windows[ch][i] = RESET_TEMP;
			external_mode = 1'b0;
			mismatches = 0;
		endfunction

		function void write_register(reg_index_t idx, logic [PDATA_W-1:0] value);
			if (idx == REG_USE_EXTERNAL) external_mode = value[0];
		endfunction

		// Middle entry of the window sorted from largest down.
		function temp_t window_median(int ch);
			temp_t ordered[TAP_COUNT];
			temp_t v;
			int j;
			for (int i = 0; i < TAP_COUNT; i++) begin
				v = windows[ch][i];
				j = i;
				while (j > 0 && ordered[j-1] < v) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = v;
			end
			return ordered[TAP_COUNT/2];
		endfunction

		function void note_sample(temp_t a, temp_t b, temp_t c, temp_t ext);
			temp_t fresh[3];
			temp_t lowest;
			temp_t m;
			if (external_mode) begin
				expected_temps.push_back(ext);
				return;
			end
			fresh = '{a, b, c};
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 1; i < TAP_COUNT; i++) windows[ch][i-1] = windows[ch][i];
				windows[ch][TAP_COUNT-1] = fresh[ch];
			end
			lowest = window_median(0);
			for (int ch = 1; ch < 3; ch++) begin
				m = window_median(ch);
				if (m < lowest) lowest = m;
			end
			expected_temps.push_back(lowest);
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10) $display("%0t: %s", $time, msg);
		endfunction

		function void check_result(temp_t got);
			temp_t want;
			if (expected_temps.size() == 0) begin
				note_mismatch($sformatf("unexpected filtered_temp word %0d", got));
				return;
			end
			want = expected_temps.pop_front();
			if (got !== want)
				note_mismatch($sformatf("filtered_temp expected %0d, got %0d", want, got));
		endfunction

		function int pending();
			return expected_temps.size();
		endfunction
	endclass

endpackage

// ===== verif/tb_three_sensor_median_min_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_sensor_median_min_filter
// Drives sample words into the median/minimum filter under varying amounts of
// sender idling and receiver stalling, switches the source register between
// phases, and compares every result word with a predicted temperature.
// ----------------------------------------------------------------------------
module tb_three_sensor_median_min_filter;
	import tsmm_pkg::*;
	import tsmm_tb_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic  sample_valid = 1'b0;
	logic  sample_stall;
	temp_t sample_a = '0;
	temp_t sample_b = '0;
	temp_t sample_c = '0;
	temp_t external_temp = '0;

	logic  result_valid;
	logic  result_stall = 1'b0;
	temp_t filtered_temp;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// Idling knobs, in percent per cycle, changed between phases.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	// While set, the receiver refuses every result word.
	logic hold_off = 1'b0;
	int cycle_count = 0;

	min_median_tracker tracker;

	three_sensor_median_min_filter #(
		.WINDOW_LEN(TAP_COUNT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_a     (sample_a),
		.sample_b     (sample_b),
		.sample_c     (sample_c),
		.external_temp(external_temp),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.filtered_temp(filtered_temp),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// Watchdog: a run that hangs is reported as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver side. The stall is decided fresh every cycle, except while a
	// long hold-off is running, which keeps the result channel blocked so that
	// the pipeline fills up and pushes back on the sample channel.
	always @(posedge clk) begin
		if (hold_off)
			result_stall <= 1'b1;
		else
			result_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Every result word taken at this edge is checked against the oldest
	// prediction. Signals are read in the active region, so they still hold
	// the values the block saw at the edge.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) tracker.check_result(filtered_temp);
	end

	// Temperatures biased toward the interesting spots: both extremes, the
	// full 16-bit range, and a narrow band around the reset value so that the
	// windows often hold ties and close neighbors.
	function automatic temp_t random_temp();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return temp_t'($urandom);
			default: return temp_t'(RESET_TEMP - 50 + $urandom_range(100));
		endcase
	endfunction

	// Offers one sample word, with random idle cycles ahead of it, and holds
	// it until the block takes it. Valid stays high afterwards, so back-to-back
	// words never drop it; the caller lowers it after the last word.
	task automatic send_word(input temp_t a, input temp_t b, input temp_t c,
			input temp_t ext);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid  <= 1'b1;
		sample_a      <= a;
		sample_b      <= b;
		sample_c      <= c;
		external_temp <= ext;
		do @(posedge clk); while (sample_stall);
		tracker.note_sample(a, b, c, ext);
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++)
			send_word(random_temp(), random_temp(), random_temp(), temp_t'($urandom));
		sample_valid <= 1'b0;
	endtask

	// Each word gives exactly one result, so an empty prediction queue means
	// the block has nothing left in flight.
	task automatic wait_drained();
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge where psel, penable, pwrite and pready are all high.
	task automatic write_register(input reg_index_t idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		tracker.write_register(idx, value);
	endtask

	// Switches the source once the pipeline is empty. The upper bits carry
	// random junk, which the block must ignore; now and then the unused
	// register address is written as well.
	task automatic select_source(input bit external);
		logic [PDATA_W-1:0] value;
		wait_drained();
		value = $urandom;
		value[0] = external;
		write_register(REG_USE_EXTERNAL, value);
		if ($urandom_range(1)) write_register(REG_UNUSED, $urandom);
	endtask

	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write to the unused address must leave the source on the sensors.
		write_register(REG_UNUSED, 32'h0000_0001);

		// Directed part. Drive windows a and b to one extreme, then the other, so
		// the medians and the minimum swing across the full signed range.
		repeat (5) send_word(16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000);
		repeat (5) send_word(16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh7FFF);
		send_word(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
		send_word(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
		send_word(RESET_TEMP, RESET_TEMP, RESET_TEMP, RESET_TEMP);
		sample_valid <= 1'b0;

		// External mode: the external temperature passes through and the
		// sensor samples must not reach the windows.
		select_source(1'b1);
		send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
		send_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		send_word(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000);
		send_word(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'shFFFF);
		send_word(16'sh0000, 16'sh0000, 16'sh0000, 16'sh5555);
		send_word(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shAAAA);
		sample_valid <= 1'b0;

		// Only bit 0 counts: all upper bits set with bit 0 clear selects the
		// sensors again, and the windows pick up where they left off.
		wait_drained();
		write_register(REG_USE_EXTERNAL, 32'hFFFF_FFFE);
		write_register(REG_UNUSED, 32'hFFFF_FFFF);
		send_word(16'shFFFF, 16'sh0001, 16'sh0000, 16'sh1234);
		send_word(16'sh0001, 16'sh0000, 16'shFFFF, 16'sh4321);
		send_word(16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF);
		sample_valid <= 1'b0;

		// Back-pressure: the receiver holds off for a long stretch while the
		// sender keeps offering words, so both pipeline stages fill and the
		// block has to stall its input.
		wait_drained();
		fork
			begin
				hold_off <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off <= 1'b0;
			end
			send_random(40);
		join

		// Random phases with different idling mixes. Most words go through the
		// sensor windows; a shorter external stretch follows in each phase.
		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 84;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 84;
				end
				default: begin
					sender_idle_pct = 24;
					receiver_stall_pct = 24;
				end
			endcase
			select_source(1'b0);
			send_random(270);
			select_source(1'b1);
			send_random(60);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.note_mismatch($sformatf("%0d filtered_temp words never arrived",
				tracker.pending()));
		if (tracker.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
